/* sv/ftr_pkg.sv */
// ----------------------------------------------------------------------------
// ftr_pkg
// shared constants, types and helpers for the fuzzy t-norm / t-conorm reducer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftr_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int VAL_W         = FRACTION_BITS + 1;
  localparam int IN_W          = FRACTION_BITS + 2;
  localparam int S_TDATA_W     = ((IN_W + 7) / 8) * 8;
  localparam int M_TDATA_W     = ((VAL_W + 7) / 8) * 8;
  localparam int MODE_W        = 3;

  localparam logic [VAL_W-1:0] ONE  = VAL_W'(1) << FRACTION_BITS;
  localparam logic [VAL_W-1:0] ZERO = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_MIN  = 3'd0,
    MODE_LUK  = 3'd1,
    MODE_PROD = 3'd2,
    MODE_MAX  = 3'd3,
    MODE_BSUM = 3'd4,
    MODE_PSUM = 3'd5
  } mode_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             missing;
    logic             error;
  } result_t;

  function automatic logic [VAL_W-1:0] identity_of(input logic [MODE_W-1:0] mode);
    logic [VAL_W-1:0] id;
    case (mode)
      MODE_MAX, MODE_BSUM, MODE_PSUM: id = ZERO;
      default:                        id = ONE;
    endcase
    return id;
  endfunction

endpackage

`default_nettype wire

/* sv/ftr_fold_op.sv */
// ----------------------------------------------------------------------------
// ftr_fold_op
// combines the accumulator with one in-range value under the selected operator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftr_fold_op (
  input  wire logic [ftr_pkg::MODE_W-1:0] mode,
  input  wire logic [ftr_pkg::VAL_W-1:0]  acc,
  input  wire logic [ftr_pkg::VAL_W-1:0]  val,
  output logic      [ftr_pkg::VAL_W-1:0]  folded
);
  import ftr_pkg::*;

  logic [2*VAL_W-1:0] full_prod;
  logic [VAL_W-1:0]   prod;
  logic [VAL_W:0]     sum;
  logic [VAL_W:0]     psum;
  logic [VAL_W:0]     one_ext;

  assign one_ext   = {1'b0, ONE};
  assign full_prod = {{VAL_W{1'b0}}, acc} * {{VAL_W{1'b0}}, val};
  assign prod      = full_prod[VAL_W-1+FRACTION_BITS:FRACTION_BITS];
  assign sum       = {1'b0, acc} + {1'b0, val};
  assign psum      = sum - {1'b0, prod};

  always_comb begin
    case (mode)
      MODE_LUK: begin
        if (sum > one_ext) begin
          folded = VAL_W'(sum - one_ext);
        end else begin
          folded = ZERO;
        end
      end
      MODE_PROD: folded = prod;
      MODE_MAX:  folded = (val > acc) ? val : acc;
      MODE_BSUM: folded = (sum > one_ext) ? ONE : sum[VAL_W-1:0];
      MODE_PSUM: folded = (psum > one_ext) ? ONE : psum[VAL_W-1:0];
      default:   folded = (val < acc) ? val : acc;
    endcase
  end

endmodule

`default_nettype wire

/* sv/ftr_accum.sv */
// ----------------------------------------------------------------------------
// ftr_accum
// accumulator and run flags; folds one registered element per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftr_accum (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [ftr_pkg::MODE_W-1:0] mode,
  input  wire logic                       restart,
  input  wire logic [ftr_pkg::MODE_W-1:0] restart_mode,
  input  wire logic                       step,
  input  wire logic [ftr_pkg::IN_W-1:0]   value,
  input  wire logic                       missing,
  input  wire logic                       last,
  output ftr_pkg::result_t                result
);
  import ftr_pkg::*;

  logic [VAL_W-1:0] accumulator;
  logic [VAL_W-1:0] accumulator_next;
  logic             missing_seen;
  logic             missing_seen_next;
  logic             error_seen;
  logic             error_seen_next;
  logic             in_range;
  logic [VAL_W-1:0] folded;

  // sign clear and magnitude no more than one
  assign in_range = !value[IN_W-1] && (value[IN_W-2:0] <= (IN_W-1)'(ONE));

  ftr_fold_op u_fold_op (
    .mode   (mode),
    .acc    (accumulator),
    .val    (value[VAL_W-1:0]),
    .folded (folded)
  );

  always_comb begin
    accumulator_next  = accumulator;
    missing_seen_next = missing_seen;
    error_seen_next   = error_seen;
    if (!missing_seen) begin
      if (missing) begin
        missing_seen_next = 1'b1;
      end else if (!in_range) begin
        error_seen_next = 1'b1;
      end else begin
        accumulator_next = folded;
      end
    end
    result.missing = missing_seen_next;
    result.error   = error_seen_next;
    result.value   = (missing_seen_next || error_seen_next) ? ZERO : accumulator_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= identity_of(MODE_MIN);
      missing_seen <= 1'b0;
      error_seen   <= 1'b0;
    end else if (restart) begin
      accumulator  <= identity_of(restart_mode);
      missing_seen <= 1'b0;
      error_seen   <= 1'b0;
    end else if (step) begin
      if (last) begin
        accumulator  <= identity_of(mode);
        missing_seen <= 1'b0;
        error_seen   <= 1'b0;
      end else begin
        accumulator  <= accumulator_next;
        missing_seen <= missing_seen_next;
        error_seen   <= error_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/fuzzy_tnorm_tconorm_reducer.sv */
// ----------------------------------------------------------------------------
// fuzzy_tnorm_tconorm_reducer
// folds a stream of fuzzy truth values with a selectable t-norm or t-conorm
// path: the last element passes the input register, then the result register once it is free
// throughput: one element per cycle, except while a last element waits for a blocked result
// reset: synchronous; mode returns to min, accumulator to one, flags clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_tnorm_tconorm_reducer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ftr_pkg::MODE_W-1:0]    cfg_data,   // operator_mode
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ftr_pkg::S_TDATA_W-1:0] s_tdata,    // truth_value, zero pad
  input  wire logic                          s_tuser,    // value_missing
  input  wire logic                          s_tlast,    // last_element
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [ftr_pkg::M_TDATA_W-1:0] m_tdata,    // folded_value, zero pad
  output logic      [1:0]                    m_tuser     // result_missing, range_error
);
  import ftr_pkg::*;

  logic [MODE_W-1:0] mode;
  logic              in_valid;
  logic [IN_W-1:0]   in_value;
  logic              in_missing;
  logic              in_last;
  logic              out_free;
  logic              step;
  logic              cfg_write;
  result_t           result;
  result_t           out_result;

  // mode writes only land while the input and result registers are empty
  assign cfg_ready = !in_valid && !m_tvalid;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;
  assign step      = in_valid && (!in_last || out_free);
  assign s_tready  = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MIN;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_value   <= s_tdata[IN_W-1:0];
      in_missing <= s_tuser;
      in_last    <= s_tlast;
    end
  end

  ftr_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .restart      (cfg_write),
    .restart_mode (cfg_data),
    .step         (step),
    .value        (in_value),
    .missing      (in_missing),
    .last         (in_last),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(M_TDATA_W-VAL_W){1'b0}}, out_result.value};
  assign m_tuser = {out_result.error, out_result.missing};

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != 2'b00) |-> m_tdata == '0)
    else $error("flagged result carries a nonzero value");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VAL_W-1:0] <= ONE)
    else $error("result value above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && in_last && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* sim/fuzzy_tnorm_tconorm_reducer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_tnorm_tconorm_reducer_test
// self-checking bench for the t-norm / t-conorm reducer: a directed table of
// extremes, flag cases and every operator code, then random runs under each
// mode with random idling on both streams, one long output hold-off and
// drain pauses between mode writes; results are checked against the table's
// expected values or a model kept in the bench
// ----------------------------------------------------------------------------

module fuzzy_tnorm_tconorm_reducer_test;
  import ftr_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int RANDOM_ITEMS     = 700;
  localparam int SETTLE_CYCLES    = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int IDLE_PCT         = 28;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int DIRECTED_ROWS    = 26;
  localparam int CALM_FIRST       = 3;
  localparam int CALM_LAST        = 4;
  localparam int HOLD_PHASE       = 6;

  // codes outside the defined operators, folded as min
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam logic [MODE_W-1:0] PHASE_MODES [8] = '{
    MODE_PSUM, MODE_MIN, MODE_SPARE_7, MODE_PROD,
    MODE_LUK, MODE_MAX, MODE_BSUM, MODE_SPARE_6
  };

  localparam logic [IN_W-1:0] IN_ONE      = IN_W'(ONE);
  localparam logic [IN_W-1:0] IN_MOST_NEG = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic [IN_W-1:0] IN_MOST_POS = {1'b0, {(IN_W-1){1'b1}}};

  localparam result_t RES_ZERO = '{value: ZERO, missing: 1'b0, error: 1'b0};
  localparam result_t RES_ONE  = '{value: ONE,  missing: 1'b0, error: 1'b0};
  localparam result_t RES_ERR  = '{value: ZERO, missing: 1'b0, error: 1'b1};
  localparam result_t RES_MISS = '{value: ZERO, missing: 1'b1, error: 1'b0};
  localparam result_t RES_BOTH = '{value: ZERO, missing: 1'b1, error: 1'b1};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IN_W-1:0]   value;
    logic              miss;
    logic              last;
    logic              typed;
    result_t           want;
  } script_row_t;

  script_row_t script [DIRECTED_ROWS] = '{
    '{MODE_MIN,     IN_ONE,             1'b0, 1'b1, 1'b1, RES_ONE},
    '{MODE_MIN,     IN_W'(0),           1'b0, 1'b1, 1'b1, RES_ZERO},
    '{MODE_MIN,     IN_W'(-1),          1'b0, 1'b1, 1'b1, RES_ERR},
    '{MODE_MIN,     IN_ONE + 1'b1,      1'b0, 1'b1, 1'b1, RES_ERR},
    '{MODE_MIN,     IN_MOST_NEG,        1'b1, 1'b1, 1'b1, RES_MISS},
    // range error ahead of a missing value raises both flags
    '{MODE_MIN,     IN_MOST_NEG,        1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_MIN,     IN_W'(0),           1'b1, 1'b0, 1'b0, RES_ZERO},
    '{MODE_MIN,     IN_MOST_POS,        1'b0, 1'b1, 1'b1, RES_BOTH},
    // bad value after a missing one is ignored
    '{MODE_MIN,     IN_W'(0),           1'b1, 1'b0, 1'b0, RES_ZERO},
    '{MODE_MIN,     IN_W'(-5),          1'b0, 1'b1, 1'b1, RES_MISS},
    '{MODE_LUK,     IN_W'(50000),       1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_LUK,     IN_W'(40000),       1'b0, 1'b1, 1'b0, RES_ZERO},
    '{MODE_LUK,     IN_ONE,             1'b0, 1'b1, 1'b1, RES_ONE},
    '{MODE_PROD,    IN_W'(32768),       1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_PROD,    IN_W'(32768),       1'b0, 1'b1, 1'b0, RES_ZERO},
    '{MODE_PROD,    IN_W'(65535),       1'b0, 1'b1, 1'b0, RES_ZERO},
    '{MODE_MAX,     IN_W'(0),           1'b0, 1'b1, 1'b1, RES_ZERO},
    '{MODE_MAX,     IN_W'(12345),       1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_MAX,     IN_MOST_POS,        1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_MAX,     IN_W'(100),         1'b0, 1'b1, 1'b1, RES_ERR},
    '{MODE_BSUM,    IN_ONE,             1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_BSUM,    IN_ONE,             1'b0, 1'b1, 1'b1, RES_ONE},
    '{MODE_PSUM,    IN_W'(40000),       1'b0, 1'b0, 1'b0, RES_ZERO},
    '{MODE_PSUM,    IN_W'(50000),       1'b0, 1'b1, 1'b0, RES_ZERO},
    '{MODE_SPARE_6, IN_W'(1000),        1'b0, 1'b1, 1'b0, RES_ZERO},
    '{MODE_SPARE_7, IN_ONE,             1'b0, 1'b1, 1'b1, RES_ONE}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [MODE_W-1:0]    cfg_data  = MODE_MIN;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;    // truth_value, zero pad
  logic                 s_tuser   = 1'b0;  // value_missing
  logic                 s_tlast   = 1'b0;  // last_element
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;           // folded_value, zero pad
  logic [1:0]           m_tuser;           // result_missing, range_error

  // bench copy of the fold state
  logic [MODE_W-1:0] mode_reg     = MODE_MIN;
  logic [VAL_W-1:0]  fold_acc     = ONE;
  logic              fold_missing = 1'b0;
  logic              fold_error   = 1'b0;
  result_t           pending_results [$];

  int  cycle_count     = 0;
  int  elements_sent   = 0;
  int  results_checked = 0;
  int  missing_results = 0;
  int  error_results   = 0;
  int  mismatch_count  = 0;
  int  mode_writes     = 0;
  int  hold_left       = 0;
  bit  hold_done       = 1'b0;
  bit  hold_req        = 1'b0;
  bit  calm            = 1'b0;

  fuzzy_tnorm_tconorm_reducer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic mode_t active_op(input logic [MODE_W-1:0] m);
    return (m <= MODE_PSUM) ? mode_t'(m) : MODE_MIN;
  endfunction

  function automatic logic [VAL_W-1:0] combine(input mode_t op, input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] v);
    logic [47:0] prod;
    logic [47:0] sum;
    logic [47:0] r;
    prod = (48'(a) * 48'(v)) >> FRACTION_BITS;
    sum  = 48'(a) + 48'(v);
    case (op)
      MODE_LUK:  r = (sum > 48'(ONE)) ? sum - 48'(ONE) : '0;
      MODE_PROD: r = prod;
      MODE_MAX:  r = (v > a) ? 48'(v) : 48'(a);
      MODE_BSUM: r = (sum > 48'(ONE)) ? 48'(ONE) : sum;
      MODE_PSUM: r = (sum - prod > 48'(ONE)) ? 48'(ONE) : sum - prod;
      default:   r = (v < a) ? 48'(v) : 48'(a);
    endcase
    return r[VAL_W-1:0];
  endfunction

  task automatic restart_fold();
    fold_acc     = (active_op(mode_reg) >= MODE_MAX) ? ZERO : ONE;
    fold_missing = 1'b0;
    fold_error   = 1'b0;
  endtask

  task automatic fold_in(input logic [IN_W-1:0] raw, input logic miss, input logic last,
                         output bit done, output result_t res);
    logic signed [IN_W-1:0] tv;
    tv   = raw;
    done = 1'b0;
    res  = RES_ZERO;
    if (!fold_missing) begin
      if (miss) begin
        fold_missing = 1'b1;
      end else if (tv < 0 || tv > $signed({1'b0, ONE})) begin
        fold_error = 1'b1;
      end else begin
        fold_acc = combine(active_op(mode_reg), fold_acc, raw[VAL_W-1:0]);
      end
    end
    if (last) begin
      done        = 1'b1;
      res.value   = (fold_missing || fold_error) ? ZERO : fold_acc;
      res.missing = fold_missing;
      res.error   = fold_error;
      restart_fold();
    end
  endtask

  function automatic logic [IN_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return IN_ONE;
      2:       return IN_ONE - 1'b1;
      3:       return IN_W'(1);
      default: return IN_W'($urandom_range(int'(ONE)));
    endcase
  endfunction

  task automatic send_item(input logic [IN_W-1:0] raw, input logic miss, input logic last,
                           input logic typed, input result_t want);
    bit      done;
    result_t res;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(raw);
    s_tuser  <= miss;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    elements_sent++;
    fold_in(raw, miss, last, done, res);
    if (done) pending_results.push_back(typed ? want : res);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_reg = m;
    restart_fold();
    mode_writes++;
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES)
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
               field, cycle_count, want, got);
  endtask

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result transfer", 0, 32'(m_tdata));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        missing_results += int'(want.missing);
        error_results   += int'(want.error);
        if (m_tdata[VAL_W-1:0] !== want.value)
          note_mismatch("folded_value", 32'(want.value), 32'(m_tdata[VAL_W-1:0]));
        if (m_tuser[0] !== want.missing)
          note_mismatch("result_missing", 32'(want.missing), 32'(m_tuser[0]));
        if (m_tuser[1] !== want.error)
          note_mismatch("range_error", 32'(want.error), 32'(m_tuser[1]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int              row;
    int              phase;
    int              target;
    int              run_len;
    int              k;
    bit              noisy;
    logic [IN_W-1:0] raw;
    logic            miss;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, starting in the reset mode
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (script[row].mode != mode_reg) write_mode(script[row].mode);
      send_item(script[row].value, script[row].miss, script[row].last,
                script[row].typed, script[row].want);
    end

    // random runs, one mode per phase
    phase = 0;
    while (elements_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      write_mode((phase < 8) ? PHASE_MODES[phase] : MODE_W'($urandom_range(7)));
      calm     <= (phase >= CALM_FIRST && phase <= CALM_LAST);
      hold_req <= (phase == HOLD_PHASE);
      target = elements_sent + $urandom_range(40, 60);
      while (elements_sent < target) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
        if (phase == HOLD_PHASE) run_len = 1;
        noisy = ($urandom_range(99) < 15);
        for (k = 0; k < run_len; k++) begin
          raw  = pick_value();
          miss = 1'b0;
          if (noisy) begin
            case ($urandom_range(9))
              0, 1, 2: begin
                miss = 1'b1;
                raw  = IN_W'($urandom);
              end
              3, 4, 5: raw = IN_W'($urandom);
              default: ;
            endcase
          end
          send_item(raw, miss, k == run_len - 1, 1'b0, RES_ZERO);
        end
      end
      phase++;
    end
    drain();

    $display("%0d elements over %0d mode writes (codes 0 to 7), with idling and a long hold-off",
             elements_sent, mode_writes);
    $display("%0d results checked: %0d missing, %0d range error, %0d mismatches",
             results_checked, missing_results, error_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
